### rtl/core/blur_7x7_stream_defines.svh
// ----------------------------------------------------------------------------
// blur_7x7_stream assertion macros
// Concurrent checks used at the end of the top level; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef BLUR_7X7_STREAM_DEFINES_SVH
`define BLUR_7X7_STREAM_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BL7_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("blur_7x7_stream: same-cycle check failed");
// next-cycle implication
`define BL7_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("blur_7x7_stream: next-cycle check failed");
`else
`define BL7_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BL7_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/bl7_pkg.sv
// ----------------------------------------------------------------------------
// bl7_pkg
// Shared constants, kernel tables and helper functions for the 7x7 blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bl7_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WINDOW_DEF    = 7;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 11;
    localparam int ROW_W      = 11;
    localparam int CFG_RST    = 512;
    localparam int MIN_SIZE   = 7;
    localparam int HEIGHT_CAP = 1024;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int FIFO_AW    = 3;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    localparam int WT_W    = 6;
    localparam int MAGIC_W = 18;

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] blurred;
        logic             frame_end;
    } t_res;

    localparam logic [WT_W-1:0] K7 [7][7] = '{
        '{6'd1, 6'd1, 6'd1, 6'd2, 6'd1, 6'd1, 6'd1},
        '{6'd1, 6'd1, 6'd2, 6'd2, 6'd2, 6'd1, 6'd1},
        '{6'd1, 6'd2, 6'd3, 6'd3, 6'd3, 6'd2, 6'd1},
        '{6'd2, 6'd2, 6'd3, 6'd4, 6'd3, 6'd2, 6'd2},
        '{6'd1, 6'd2, 6'd3, 6'd3, 6'd3, 6'd2, 6'd1},
        '{6'd1, 6'd1, 6'd2, 6'd2, 6'd2, 6'd1, 6'd1},
        '{6'd1, 6'd1, 6'd1, 6'd2, 6'd1, 6'd1, 6'd1}
    };

    localparam logic [WT_W-1:0] K5 [5][5] = '{
        '{6'd1,  6'd4,  6'd7,  6'd4,  6'd1},
        '{6'd4,  6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd7,  6'd26, 6'd41, 6'd26, 6'd7},
        '{6'd4,  6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd1,  6'd4,  6'd7,  6'd4,  6'd1}
    };

    localparam logic [WT_W-1:0] K3 [3][3] = '{
        '{6'd1, 6'd2, 6'd1},
        '{6'd2, 6'd4, 6'd2},
        '{6'd1, 6'd2, 6'd1}
    };

    // window radius picked by the window parameter
    function automatic int rad_of(int window);
        if (window >= 6) begin
            return 3;
        end
        if (window >= 4) begin
            return 2;
        end
        return 1;
    endfunction

    function automatic int kern_wt(int rad, int i, int j);
        if (rad == 3) begin
            return int'(K7[i][j]);
        end
        if (rad == 2) begin
            return int'(K5[i][j]);
        end
        return int'(K3[i][j]);
    endfunction

    function automatic int kern_sum(int rad);
        int s;
        s = 0;
        for (int i = 0; i < 2 * rad + 1; i++) begin
            for (int j = 0; j < 2 * rad + 1; j++) begin
                s = s + kern_wt(rad, i, j);
            end
        end
        return s;
    endfunction

    // reciprocal of the kernel divisor: q = (acc * magic) >> shift, exact over acc range
    function automatic int div_magic(int rad);
        if (rad == 3) begin
            return 99865;
        end
        if (rad == 2) begin
            return 245821;
        end
        return 1;
    endfunction

    function automatic int div_shift(int rad);
        if (rad == 3) begin
            return 23;
        end
        if (rad == 2) begin
            return 26;
        end
        return 4;
    endfunction

endpackage

`default_nettype wire

### rtl/core/blur_7x7_stream.sv
// Path: stage-1 registers, window shift, column sum, total, product, then the result queue.
// Throughput: one item per cycle while ready; window and line buffers per item, adders always.
// Results trail the input stream by 3 rows plus 3 pixels; 3*width+3 drain items flush a frame.
// Input ready drops only when 8 results are queued or in flight (credit count).
// Reset (synchronous, active low) clears counters, valids and queue; both sizes go to 512.
// Line buffers and window are not cleared; out-of-image taps are masked to zero.
// ----------------------------------------------------------------------------
// blur_7x7_stream
// Streaming 7x7 integer blur: six row delay lines feed a chain of window
// column cells, followed by a registered adder tree and reciprocal divide.
// ----------------------------------------------------------------------------
`default_nettype none

`include "blur_7x7_stream_defines.svh"

module blur_7x7_stream import bl7_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int WINDOW    = WINDOW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic               i_drain,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_blurred,
    output logic               o_frame_end,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int RAD    = rad_of(WINDOW);
    localparam int SPAN   = 2 * RAD + 1;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int EW     = $clog2(MAX_WIDTH + 1);
    localparam int XW     = EW + 1;
    localparam int YW     = ROW_W + 1;
    localparam int CMP_W  = (EW > CFG_W) ? EW : CFG_W;
    localparam int KSUM   = kern_sum(RAD);
    localparam int ACC_W  = $clog2(KSUM * 255 + 1);
    localparam int MAGIC  = div_magic(RAD);
    localparam int SHIFT  = div_shift(RAD);
    localparam int PROD_W = ACC_W + MAGIC_W;
    localparam int W_RST  = (CFG_RST > MAX_WIDTH) ? MAX_WIDTH : CFG_RST;

    // ---------------- configuration port ----------------
    logic             cfg_wr;
    t_reg_idx         cfg_idx;
    logic [CFG_W-1:0] cfg_val;
    logic [CMP_W-1:0] cfg_cmp;
    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;
    logic [EW-1:0]    r_eff_w;
    logic [ROW_W-1:0] r_eff_h;
    logic [EW-1:0]    n_eff_w;
    logic [ROW_W-1:0] n_eff_h;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg_idx'(paddr[2]);
    assign cfg_val = pwdata[CFG_W-1:0];
    assign cfg_cmp = CMP_W'(cfg_val);

    always_comb begin
        if (cfg_cmp < CMP_W'(MIN_SIZE)) begin
            n_eff_w = EW'(MIN_SIZE);
        end else if (cfg_cmp > CMP_W'(MAX_WIDTH)) begin
            n_eff_w = EW'(MAX_WIDTH);
        end else begin
            n_eff_w = EW'(cfg_cmp);
        end
        if (cfg_val < CFG_W'(MIN_SIZE)) begin
            n_eff_h = ROW_W'(MIN_SIZE);
        end else if (cfg_val > CFG_W'(HEIGHT_CAP)) begin
            n_eff_h = ROW_W'(HEIGHT_CAP);
        end else begin
            n_eff_h = ROW_W'(cfg_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W'(CFG_RST);
            r_cfg_h <= CFG_W'(CFG_RST);
            r_eff_w <= EW'(W_RST);
            r_eff_h <= ROW_W'(CFG_RST);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WIDTH: begin
                    r_cfg_w <= cfg_val;
                    r_eff_w <= n_eff_w;
                end
                REG_HEIGHT: begin
                    r_cfg_h <= cfg_val;
                    r_eff_h <= n_eff_h;
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = PDATA_W'(r_cfg_w);
            REG_HEIGHT: prdata = PDATA_W'(r_cfg_h);
        endcase
    end

    // ---------------- raster position and input transfer ----------------
    localparam int USED_W = FIFO_AW + 1;

    logic              in_xfer;
    logic              out_xfer;
    logic [USED_W-1:0] r_used;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic              c_ge;
    logic              emit;
    logic              last;
    logic [EW-1:0]     col_p1;
    logic [EW-1:0]     x_wrap;
    t_pix              pix_v;
    logic [COL_W-1:0]  n_x;
    logic [ROW_W-1:0]  n_y;

    assign o_ready  = (r_used < USED_W'(FIFO_DEPTH));
    assign in_xfer  = i_valid & o_ready;
    assign out_xfer = o_valid & i_ready;

    assign c_ge   = (r_col >= COL_W'(RAD));
    assign emit   = (r_row > ROW_W'(RAD)) || ((r_row == ROW_W'(RAD)) && c_ge);
    // the last result of a frame falls on row height+RAD, column RAD-1
    assign last   = (r_row == r_eff_h + ROW_W'(RAD)) && (r_col == COL_W'(RAD - 1));
    assign col_p1 = EW'(r_col) + EW'(1);
    assign x_wrap = r_eff_w - EW'(RAD) + EW'(r_col);
    assign pix_v  = (i_drain || (r_row >= r_eff_h)) ? '0 : i_pixel;
    assign n_x    = c_ge ? (r_col - COL_W'(RAD)) : x_wrap[COL_W-1:0];
    assign n_y    = c_ge ? (r_row - ROW_W'(RAD)) : (r_row - ROW_W'(RAD + 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_used <= '0;
        end else begin
            r_used <= r_used + USED_W'(in_xfer && emit) - USED_W'(out_xfer);
            if (cfg_wr) begin
                r_col <= '0;
                r_row <= '0;
            end else if (in_xfer) begin
                if (emit && last) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (col_p1 >= r_eff_w) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // ---------------- stage 1: accepted item, line buffer read ----------------
    t_pix             r_s1_pix;
    logic [COL_W-1:0] r_s1_addr;
    logic [COL_W-1:0] r_s1_x;
    logic [ROW_W-1:0] r_s1_y;
    logic             r_s1_vld;
    logic             r_s1_emit;
    logic             r_s1_last;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_pix  <= pix_v;
            r_s1_addr <= r_col;
            r_s1_x    <= n_x;
            r_s1_y    <= n_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_emit <= 1'b0;
            r_s1_last <= 1'b0;
        end else begin
            r_s1_vld  <= in_xfer;
            r_s1_emit <= in_xfer && emit;
            r_s1_last <= in_xfer && emit && last;
        end
    end

    logic [SPAN-2:0][PIX_W-1:0] lb_rd;
    logic [SPAN-1:0][PIX_W-1:0] col_new;

    // each delay line passes the row it drops on to the next one
    for (genvar j = 0; j < SPAN - 1; j++) begin : g_lb
        t_pix lb_wd;
        if (j == 0) begin : g_first
            assign lb_wd = r_s1_pix;
        end else begin : g_next
            assign lb_wd = lb_rd[j-1];
        end
        bl7_linebuf #(
            .DEPTH (MAX_WIDTH),
            .AW    (COL_W)
        ) u_lb (
            .i_clk   (i_clk),
            .i_we    (r_s1_vld),
            .i_waddr (r_s1_addr),
            .i_wdata (lb_wd),
            .i_re    (in_xfer),
            .i_raddr (r_col),
            .o_rdata (lb_rd[j])
        );
    end

    always_comb begin
        col_new[0] = r_s1_pix;
        for (int j = 1; j < SPAN; j++) begin
            col_new[j] = lb_rd[j-1];
        end
    end

    // ---------------- stage 2: window shift and edge masks ----------------
    logic [SPAN-1:0] r_s2_colok;
    logic [SPAN-1:0] r_s2_rowok;
    logic [SPAN-1:0] n_colok;
    logic [SPAN-1:0] n_rowok;
    logic [XW-1:0]   xs;
    logic [YW-1:0]   ys;
    logic            r_s2_emit;
    logic            r_s2_last;

    assign xs = XW'(r_s1_x) + XW'(RAD);
    assign ys = YW'(r_s1_y) + YW'(RAD);

    // tap k covers column x+RAD-k, tap j covers row y+RAD-j
    always_comb begin
        for (int k = 0; k < SPAN; k++) begin
            n_colok[k] = (xs >= XW'(k)) && (xs < XW'(r_eff_w) + XW'(k));
            n_rowok[k] = (ys >= YW'(k)) && (ys < YW'(r_eff_h) + YW'(k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2_colok <= n_colok;
            r_s2_rowok <= n_rowok;
        end
    end

    // ---------------- stage 3: column cells ----------------
    logic [SPAN-1:0][SPAN-1:0][PIX_W-1:0] win_col;
    logic [SPAN-1:0][ACC_W-1:0]           col_sum;

    for (genvar k = 0; k < SPAN; k++) begin : g_cell
        logic [SPAN-1:0][PIX_W-1:0] cell_in;
        if (k == 0) begin : g_head
            assign cell_in = col_new;
        end else begin : g_tail
            assign cell_in = win_col[k-1];
        end
        bl7_cell #(
            .RAD   (RAD),
            .COL   (k),
            .ACC_W (ACC_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_shift  (r_s1_vld),
            .i_col    (cell_in),
            .i_row_ok (r_s2_rowok),
            .i_col_ok (r_s2_colok[k]),
            .o_col    (win_col[k]),
            .o_sum    (col_sum[k])
        );
    end

    // ---------------- stages 4 and 5: total and reciprocal multiply ----------------
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic [PROD_W-1:0] r_prod;
    logic              r_s3_emit;
    logic              r_s3_last;
    logic              r_s4_emit;
    logic              r_s4_last;
    logic              r_s5_emit;
    logic              r_s5_last;

    always_comb begin
        n_acc = '0;
        for (int k = 0; k < SPAN; k++) begin
            n_acc = n_acc + col_sum[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_prod <= PROD_W'(r_acc) * PROD_W'(MAGIC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_emit <= 1'b0;
            r_s2_last <= 1'b0;
            r_s3_emit <= 1'b0;
            r_s3_last <= 1'b0;
            r_s4_emit <= 1'b0;
            r_s4_last <= 1'b0;
            r_s5_emit <= 1'b0;
            r_s5_last <= 1'b0;
        end else begin
            r_s2_emit <= r_s1_emit;
            r_s2_last <= r_s1_last;
            r_s3_emit <= r_s2_emit;
            r_s3_last <= r_s2_last;
            r_s4_emit <= r_s3_emit;
            r_s4_last <= r_s3_last;
            r_s5_emit <= r_s4_emit;
            r_s5_last <= r_s4_last;
        end
    end

    // ---------------- result queue ----------------
    t_res q_in;
    t_res q_out;

    assign q_in.blurred   = r_prod[SHIFT +: PIX_W];
    assign q_in.frame_end = r_s5_last;

    bl7_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s5_emit),
        .i_data  (q_in),
        .i_pop   (out_xfer),
        .o_valid (o_valid),
        .o_data  (q_out)
    );

    assign o_blurred   = q_out.blurred;
    assign o_frame_end = q_out.frame_end;

    // ---------------- checks ----------------
    `BL7_ASSERT_IMP(a_out_has_credit, i_clk, i_rst_n, o_valid, r_used != '0)
    `BL7_ASSERT_IMP(a_pipe_has_credit, i_clk, i_rst_n, r_s5_emit, r_used != '0)
    `BL7_ASSERT_NXT(a_frame_restart, i_clk, i_rst_n, in_xfer && emit && last, ~|{r_col, r_row})

endmodule

`default_nettype wire

### rtl/core/bl7_linebuf.sv
// ----------------------------------------------------------------------------
// bl7_linebuf
// One row delay line: simple dual-port memory with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bl7_linebuf import bl7_pkg::*; #(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_pix          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_pix          o_rdata
);

    t_pix r_mem [DEPTH];
    t_pix r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/bl7_cell.sv
// ----------------------------------------------------------------------------
// bl7_cell
// One window column: holds a vertical strip of pixels, passes it to the next
// column on shift, and registers its masked, weighted column sum.
// ----------------------------------------------------------------------------
`default_nettype none

module bl7_cell import bl7_pkg::*; #(
    parameter int RAD   = 3,
    parameter int COL   = 0,
    parameter int ACC_W = 15
) (
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  logic [2*RAD:0][PIX_W-1:0]     i_col,
    input  logic [2*RAD:0]                i_row_ok,
    input  logic                          i_col_ok,
    output logic [2*RAD:0][PIX_W-1:0]     o_col,
    output logic [ACC_W-1:0]              o_sum
);

    localparam int SPAN = 2 * RAD + 1;

    logic [SPAN-1:0][PIX_W-1:0] r_col;
    logic [ACC_W-1:0]           r_sum;
    logic [ACC_W-1:0]           n_sum;

    // entry j is the row RAD-j below the center; this cell is column RAD-COL right of it
    always_comb begin
        n_sum = '0;
        for (int j = 0; j < SPAN; j++) begin
            if (i_row_ok[j] && i_col_ok) begin
                n_sum = n_sum + ACC_W'(r_col[j])
                        * ACC_W'(kern_wt(RAD, 2 * RAD - j, 2 * RAD - COL));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
        r_sum <= n_sum;
    end

    assign o_col = r_col;
    assign o_sum = r_sum;

endmodule

`default_nettype wire

### rtl/core/bl7_outq.sv
// ----------------------------------------------------------------------------
// bl7_outq
// Small result queue between the arithmetic pipeline and the output port.
// ----------------------------------------------------------------------------
`default_nettype none

module bl7_outq import bl7_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_data,
    input  logic i_pop,
    output logic o_valid,
    output t_res o_data
);

    t_res               r_buf [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rp];

endmodule

`default_nettype wire
